// ===== sv/tgc_pkg.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier package
// Shared codes, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned GEST_W  = 3;
  localparam int unsigned MS_W    = 2;
  localparam int unsigned CFG_A_W = 3;

  // Margin applied to the button regions when a new gesture is classified.
  localparam logic [COORD_W:0] BUTTON_MARGIN = 13'd5;

  // Gesture codes.
  localparam logic [GEST_W-1:0] G_NONE        = 3'd0;
  localparam logic [GEST_W-1:0] G_LEFT        = 3'd1;
  localparam logic [GEST_W-1:0] G_RIGHT       = 3'd2;
  localparam logic [GEST_W-1:0] G_SLIDER_UP   = 3'd3;
  localparam logic [GEST_W-1:0] G_SLIDER_DOWN = 3'd4;

  // Held mouse state codes.
  localparam logic [MS_W-1:0] MS_NONE  = 2'd0;
  localparam logic [MS_W-1:0] MS_LEFT  = 2'd1;
  localparam logic [MS_W-1:0] MS_RIGHT = 2'd2;

  // Miss count at which the next miss releases a held button.
  localparam logic [1:0] MISS_LAST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_SLIDER_X_LOW   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_SLIDER_X_HIGH  = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_LEFT_BUTTON_X  = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_LEFT_BUTTON_Y  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_RIGHT_BUTTON_X = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_RIGHT_BUTTON_Y = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input word into the batch accumulators
    logic load;    // load the dividers from the finished batch sums
    logic step;    // one restoring division step
    logic commit;  // decide, update the held state, write the result
  } tgc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the result register can take a word this cycle
  } tgc_sts_t;

endpackage

`default_nettype wire

// ===== sv/touch_gesture_classifier_top.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier
// Classifies batches of packed touch samples into button and slider gestures.
// ---------------------------------------------------------------------------
// A word with batch_last passes through divider load, the steps of the
// bit-serial divider that forms the batch averages, and the final decision.
// Throughput: one sample word per cycle inside a batch; no word is taken
// from a batch end until its result is committed. Samples of the next batch
// are taken while a result waits in the result register.
// Reset (rst_n low at a clock edge) restores the register defaults, clears
// the held state, the miss counter, the batch and the result valid flag.
`default_nettype none

module touch_gesture_classifier_top #(
  parameter int unsigned MAX_BATCH    = 16,
  parameter int unsigned HOLD_SAMPLES = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration write port.
  input  wire                          cfg_we,
  input  wire  [tgc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire  [tgc_pkg::COORD_W-1:0]  cfg_wdata,
  // Sample words.
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_sample_present,
  input  wire  [tgc_pkg::WORD_W-1:0]   in_sample_word,
  input  wire                          in_batch_last,
  // Result words.
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [tgc_pkg::GEST_W-1:0]   out_gesture,
  output logic                         out_notify,
  output logic [tgc_pkg::MS_W-1:0]     out_mouse_state
);
  import tgc_pkg::*;

  // The sample counter must reach the larger of the two batch limits. The
  // sums stay below that limit times 4096, which sets the sum width and so
  // the number of divider steps.
  localparam int unsigned NMAX  = (MAX_BATCH > HOLD_SAMPLES) ? MAX_BATCH : HOLD_SAMPLES;
  localparam int unsigned CNT_W = $clog2(NMAX + 1);
  localparam int unsigned SUM_W = COORD_W + $clog2(NMAX);

  tgc_cmd_t cmd;
  tgc_sts_t sts;

  // The controller accepts words only while idle; it walks a finished batch
  // through divider load, the division steps and the final decision.
  tgc_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_batch_last (in_batch_last),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // The datapath holds the configuration, the batch and held state and the
  // result register that separates the result channel from the input side.
  tgc_datapath #(
    .MAX_BATCH    (MAX_BATCH),
    .HOLD_SAMPLES (HOLD_SAMPLES),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_sample_present (in_sample_present),
    .in_sample_word    (in_sample_word),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gesture       (out_gesture),
    .out_notify        (out_notify),
    .out_mouse_state   (out_mouse_state)
  );

endmodule

`default_nettype wire

// ===== sv/tgc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier controller
// Sequences accumulation, batch-end division and the final decision.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_ctrl #(
  parameter int unsigned SUM_W = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_batch_last,
  output logic                in_stall,
  input  tgc_pkg::tgc_sts_t   sts,
  output tgc_pkg::tgc_cmd_t   cmd
);
  import tgc_pkg::*;

  localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_batch_last) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        step_nxt  = STEP_W'(SUM_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_FIN: begin
        // Hold the decision until the result register has room.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tgc_datapath.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier datapath
// Configuration, batch accumulators, two restoring dividers, decision logic
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_datapath #(
  parameter int unsigned MAX_BATCH    = 16,
  parameter int unsigned HOLD_SAMPLES = 5,
  parameter int unsigned SUM_W        = 16,
  parameter int unsigned CNT_W        = 5
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [tgc_pkg::CFG_A_W-1:0]         cfg_addr,
  input  wire  [tgc_pkg::COORD_W-1:0]         cfg_wdata,
  input  wire                                 in_sample_present,
  input  wire  [tgc_pkg::WORD_W-1:0]          in_sample_word,
  input  tgc_pkg::tgc_cmd_t                   cmd,
  output tgc_pkg::tgc_sts_t                   sts,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [tgc_pkg::GEST_W-1:0]          out_gesture,
  output logic                                out_notify,
  output logic [tgc_pkg::MS_W-1:0]            out_mouse_state
);
  import tgc_pkg::*;

  localparam int unsigned EXT_W = SUM_W + 1;

  // Configuration registers.
  logic [COORD_W-1:0] sxl_r, sxh_r, lbx_r, lby_r, rbx_r, rby_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sxl_r <= 12'd1600;
      sxh_r <= 12'd2496;
      lbx_r <= 12'd1000;
      lby_r <= 12'd3000;
      rbx_r <= 12'd3000;
      rby_r <= 12'd3000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SLIDER_X_LOW:   sxl_r <= cfg_wdata;
        CFG_SLIDER_X_HIGH:  sxh_r <= cfg_wdata;
        CFG_LEFT_BUTTON_X:  lbx_r <= cfg_wdata;
        CFG_LEFT_BUTTON_Y:  lby_r <= cfg_wdata;
        CFG_RIGHT_BUTTON_X: rbx_r <= cfg_wdata;
        CFG_RIGHT_BUTTON_Y: rby_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Held state and batch accumulators.
  logic [MS_W-1:0]    held_r, held_nxt;
  logic [1:0]         miss_r, miss_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   up_r, up_nxt, down_r, down_nxt;
  logic [SUM_W-1:0]   xs_r, xs_nxt, ys_r, ys_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;

  logic [COORD_W-1:0] sx, sy;
  logic               holding;

  assign sx      = in_sample_word[WORD_W-1:COORD_W];
  assign sy      = in_sample_word[COORD_W-1:0];
  assign holding = (held_r == MS_LEFT) || (held_r == MS_RIGHT);

  // Dividers: X and Y are divided side by side, one quotient bit a step.
  logic [SUM_W-1:0] xq_r, yq_r;
  logic [CNT_W-1:0] xrem_r, yrem_r, div_r;
  logic [CNT_W:0]   x_trial, y_trial, div_ext;
  logic             x_ge, y_ge;

  assign div_ext = {1'b0, div_r};
  assign x_trial = {xrem_r, xq_r[SUM_W-1]};
  assign y_trial = {yrem_r, yq_r[SUM_W-1]};
  assign x_ge    = (x_trial >= div_ext);
  assign y_ge    = (y_trial >= div_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xq_r   <= xs_r;
      yq_r   <= ys_r;
      xrem_r <= '0;
      yrem_r <= '0;
      // Hold averages divide by the count; classification by count minus one.
      div_r  <= holding ? cnt_r : (cnt_r - 1'b1);
    end else if (cmd.step) begin
      xq_r   <= {xq_r[SUM_W-2:0], x_ge};
      yq_r   <= {yq_r[SUM_W-2:0], y_ge};
      xrem_r <= x_ge ? CNT_W'(x_trial - div_ext) : x_trial[CNT_W-1:0];
      yrem_r <= y_ge ? CNT_W'(y_trial - div_ext) : y_trial[CNT_W-1:0];
    end
  end

  // Decision on the averages.
  logic [EXT_W-1:0] xa, ya, sxl_e, sxh_e, lbx_e, lby_e, rbx_e, rby_e;
  logic [CNT_W:0]   up_e, down_e, quarter;
  logic             in_band, left_c, right_c, hold_hit;
  logic [GEST_W-1:0] class_g;

  assign xa      = {1'b0, xq_r};
  assign ya      = {1'b0, yq_r};
  assign sxl_e   = EXT_W'(sxl_r);
  assign sxh_e   = EXT_W'(sxh_r);
  assign lbx_e   = EXT_W'(lbx_r);
  assign lby_e   = EXT_W'(lby_r);
  assign rbx_e   = EXT_W'(rbx_r);
  assign rby_e   = EXT_W'(rby_r);
  assign up_e    = {1'b0, up_r};
  assign down_e  = {1'b0, down_r};
  assign quarter = {1'b0, cnt_r} >> 2;

  assign in_band  = (xa < sxh_e) && (xa > sxl_e);
  assign left_c   = ((xa + EXT_W'(BUTTON_MARGIN)) < lbx_e) && (ya > lby_e);
  assign right_c  = (xa > (rbx_e + EXT_W'(BUTTON_MARGIN))) && (ya > rby_e);
  assign hold_hit = (cnt_r != '0) &&
                    (((xa < lbx_e) && (ya > lby_e)) || ((xa > rbx_e) && (ya > rby_e)));

  always_comb begin
    class_g = G_NONE;
    if (cnt_r >= CNT_W'(2)) begin
      if (in_band) begin
        if (up_e >= down_e + quarter) begin
          class_g = G_SLIDER_UP;
        end else if (down_e >= up_e + quarter) begin
          class_g = G_SLIDER_DOWN;
        end
      end else if (left_c) begin
        class_g = G_LEFT;
      end else if (right_c) begin
        class_g = G_RIGHT;
      end
    end
  end

  // Result register.
  logic              out_valid_r;
  logic [GEST_W-1:0] gest_r, gest_nxt;
  logic              notify_r, notify_nxt;
  logic [MS_W-1:0]   ms_r;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    held_nxt   = held_r;
    miss_nxt   = miss_r;
    cnt_nxt    = cnt_r;
    up_nxt     = up_r;
    down_nxt   = down_r;
    xs_nxt     = xs_r;
    ys_nxt     = ys_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    gest_nxt   = G_NONE;
    notify_nxt = 1'b0;
    if (cmd.accept && in_sample_present) begin
      if (holding) begin
        if (cnt_r < CNT_W'(HOLD_SAMPLES)) begin
          xs_nxt  = xs_r + SUM_W'(sx);
          ys_nxt  = ys_r + SUM_W'(sy);
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (cnt_r < CNT_W'(MAX_BATCH)) begin
        if (cnt_r != '0) begin
          if (py_r <= sy) begin
            up_nxt = up_r + 1'b1;
          end else begin
            down_nxt = down_r + 1'b1;
          end
          xs_nxt = xs_r + SUM_W'(px_r);
          ys_nxt = ys_r + SUM_W'(py_r);
        end
        px_nxt  = sx;
        py_nxt  = sy;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.commit) begin
      if (holding) begin
        if (hold_hit) begin
          miss_nxt = '0;
        end else if (miss_r == MISS_LAST) begin
          miss_nxt   = '0;
          held_nxt   = MS_NONE;
          notify_nxt = 1'b1;
        end else begin
          miss_nxt = miss_r + 1'b1;
        end
      end else begin
        gest_nxt = class_g;
        if (class_g != G_NONE) begin
          notify_nxt = 1'b1;
          held_nxt   = ((class_g == G_LEFT) || (class_g == G_RIGHT)) ?
                       class_g[MS_W-1:0] : MS_NONE;
        end
      end
      cnt_nxt  = '0;
      up_nxt   = '0;
      down_nxt = '0;
      xs_nxt   = '0;
      ys_nxt   = '0;
      px_nxt   = '0;
      py_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= MS_NONE;
      miss_r      <= '0;
      cnt_r       <= '0;
      up_r        <= '0;
      down_r      <= '0;
      xs_r        <= '0;
      ys_r        <= '0;
      px_r        <= '0;
      py_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      miss_r <= miss_nxt;
      cnt_r  <= cnt_nxt;
      up_r   <= up_nxt;
      down_r <= down_nxt;
      xs_r   <= xs_nxt;
      ys_r   <= ys_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      gest_r   <= gest_nxt;
      notify_r <= notify_nxt;
      ms_r     <= held_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gesture     = gest_r;
  assign out_notify      = notify_r;
  assign out_mouse_state = ms_r;

endmodule

`default_nettype wire

// ===== sv/tgc_checker.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier port checker
// Checks result words seen on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [tgc_pkg::GEST_W-1:0]    out_gesture,
  input wire                          out_notify,
  input wire [tgc_pkg::MS_W-1:0]      out_mouse_state
);
  import tgc_pkg::*;

  // A stalled result word stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gesture) &&
                               $stable(out_notify) && $stable(out_mouse_state))
    else $error("result word changed while stalled");

  // A button gesture is notified and becomes the held state.
  a_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gesture == G_LEFT || out_gesture == G_RIGHT) |->
      out_notify && (out_mouse_state == out_gesture[MS_W-1:0]))
    else $error("button gesture without notify or held state");

  // A slider gesture is notified and leaves nothing held.
  a_slider: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gesture == G_SLIDER_UP || out_gesture == G_SLIDER_DOWN) |->
      out_notify && (out_mouse_state == MS_NONE))
    else $error("slider gesture without notify or with a held state");

  // A notify without a gesture is a release, so nothing stays held.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify && (out_gesture == G_NONE) |->
      (out_mouse_state == MS_NONE))
    else $error("release notify with a held state");

endmodule

bind touch_gesture_classifier_top tgc_checker u_tgc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_gesture     (out_gesture),
  .out_notify      (out_notify),
  .out_mouse_state (out_mouse_state)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// Touch gesture classifier testbench
// Drives batches of packed touch samples into the classifier under random
// handshake pressure, predicts every result word from its own model of the
// batch logic and the held button state, and compares the words field by
// field. Threshold registers are swept through defaults, extremes and random
// settings between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgc_pkg::*;

  // Block parameters, kept at the values the predictor below assumes.
  localparam int BATCH_CAP = 16;
  localparam int HOLD_CAP  = 5;

  localparam int COORD_MAX     = 4095;
  localparam int MARGIN        = 5;
  localparam int MISS_LIMIT    = 3;
  localparam int NUM_REGS      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // Register indexes beyond the last threshold; writes to them are dropped.
  localparam logic [CFG_A_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_A_W-1:0] CFG_SPARE_HI = 3'd7;

  // One result word as the block should send it.
  typedef struct {
    logic [GEST_W-1:0] gesture;
    logic              notify;
    logic [MS_W-1:0]   mouse_state;
  } gesture_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_A_W-1:0]   cfg_addr;
  logic [COORD_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_sample_present;
  logic [WORD_W-1:0]    in_sample_word;
  logic                 in_batch_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [GEST_W-1:0]    out_gesture;
  logic                 out_notify;
  logic [MS_W-1:0]      out_mouse_state;

  always #5 clk = ~clk;

  touch_gesture_classifier_top #(
    .MAX_BATCH    (BATCH_CAP),
    .HOLD_SAMPLES (HOLD_CAP)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_present (in_sample_present),
    .in_sample_word    (in_sample_word),
    .in_batch_last     (in_batch_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gesture       (out_gesture),
    .out_notify        (out_notify),
    .out_mouse_state   (out_mouse_state)
  );

  // -------------------------------------------------------------------------
  // Predictor state. The thresholds are indexed by the register index, so
  // thresh[CFG_LEFT_BUTTON_X] is the left button X edge and so on.
  // -------------------------------------------------------------------------
  int          thresh [NUM_REGS];
  logic [MS_W-1:0] held_btn;
  int          miss_run;
  int          take_count;   // samples taken into the open batch
  int          sum_x, sum_y;
  int          last_x, last_y;  // newest sample, not yet in the sums
  int          rises, falls;

  gesture_word_t expected_gestures [$];

  // Bookkeeping for the run summary and the verdict.
  int mismatch_count = 0;
  int words_sent     = 0;
  int batches_closed = 0;
  int results_seen   = 0;
  int slider_seen    = 0;
  int press_seen     = 0;
  int release_seen   = 0;
  int settings_used  = 1;

  // Idle switches: when set, that side never waits.
  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int clamp12(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Uniform pick in [lo, hi]; an empty range falls back to the whole axis.
  function automatic int pick_between(input int lo, input int hi);
    if (hi < lo) return $urandom_range(0, COORD_MAX);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [WORD_W-1:0] pack_xy(input int x, input int y);
    int cx, cy;
    cx = clamp12(x);
    cy = clamp12(y);
    return {cx[COORD_W-1:0], cy[COORD_W-1:0]};
  endfunction

  task automatic clear_open_batch();
    take_count = 0;
    sum_x      = 0;
    sum_y      = 0;
    last_x     = 0;
    last_y     = 0;
    rises      = 0;
    falls      = 0;
  endtask

  task automatic reset_model();
    thresh[CFG_SLIDER_X_LOW]   = 1600;
    thresh[CFG_SLIDER_X_HIGH]  = 2496;
    thresh[CFG_LEFT_BUTTON_X]  = 1000;
    thresh[CFG_LEFT_BUTTON_Y]  = 3000;
    thresh[CFG_RIGHT_BUTTON_X] = 3000;
    thresh[CFG_RIGHT_BUTTON_Y] = 3000;
    held_btn = MS_NONE;
    miss_run = 0;
    clear_open_batch();
  endtask

  // Gesture of a closed batch while no button is held. The average leaves
  // out the newest sample, so a batch needs two samples to say anything.
  function automatic logic [GEST_W-1:0] gesture_of_batch();
    int ax, ay, quarter;
    if (take_count < 2) return G_NONE;
    ax = sum_x / (take_count - 1);
    ay = sum_y / (take_count - 1);
    if (ax < thresh[CFG_SLIDER_X_HIGH] && ax > thresh[CFG_SLIDER_X_LOW]) begin
      quarter = take_count / 4;
      if (rises >= falls + quarter) return G_SLIDER_UP;
      if (falls >= rises + quarter) return G_SLIDER_DOWN;
      return G_NONE;
    end
    if (ax + MARGIN < thresh[CFG_LEFT_BUTTON_X] && ay > thresh[CFG_LEFT_BUTTON_Y])
      return G_LEFT;
    if (ax > thresh[CFG_RIGHT_BUTTON_X] + MARGIN && ay > thresh[CFG_RIGHT_BUTTON_Y])
      return G_RIGHT;
    return G_NONE;
  endfunction

  // Hold check: average over the samples present, no margin.
  function automatic bit finger_on_button();
    int ax, ay;
    if (take_count == 0) return 1'b0;
    ax = sum_x / take_count;
    ay = sum_y / take_count;
    if (ax < thresh[CFG_LEFT_BUTTON_X] && ay > thresh[CFG_LEFT_BUTTON_Y]) return 1'b1;
    if (ax > thresh[CFG_RIGHT_BUTTON_X] && ay > thresh[CFG_RIGHT_BUTTON_Y]) return 1'b1;
    return 1'b0;
  endfunction

  // Folds one accepted word into the model and queues the result it causes.
  task automatic absorb_word(input bit present, input logic [WORD_W-1:0] word,
                             input bit last);
    int sx, sy;
    bit holding;
    gesture_word_t res;
    sx = int'(word[23:12]);
    sy = int'(word[11:0]);
    holding = (held_btn == MS_LEFT) || (held_btn == MS_RIGHT);
    if (present) begin
      if (holding) begin
        if (take_count < HOLD_CAP) begin
          sum_x += sx;
          sum_y += sy;
          take_count++;
        end
      end else if (take_count < BATCH_CAP) begin
        if (take_count > 0) begin
          if (last_y <= sy) rises++;
          else falls++;
          sum_x += last_x;
          sum_y += last_y;
        end
        last_x = sx;
        last_y = sy;
        take_count++;
      end
    end
    if (last) begin
      res.gesture = G_NONE;
      res.notify  = 1'b0;
      if (holding) begin
        if (finger_on_button()) begin
          miss_run = 0;
        end else begin
          miss_run++;
          if (miss_run >= MISS_LIMIT) begin
            miss_run   = 0;
            held_btn   = MS_NONE;
            res.notify = 1'b1;
          end
        end
      end else begin
        res.gesture = gesture_of_batch();
        if (res.gesture != G_NONE) begin
          res.notify = 1'b1;
          if (res.gesture == G_LEFT) held_btn = MS_LEFT;
          else if (res.gesture == G_RIGHT) held_btn = MS_RIGHT;
          else held_btn = MS_NONE;
        end
      end
      res.mouse_state = held_btn;
      expected_gestures.push_back(res);
      batches_closed++;
      clear_open_batch();
    end
  endtask

  // -------------------------------------------------------------------------
  // Sender side. Each call waits its own random gap, presents the word and
  // returns at the edge that accepted it, with valid still high. The caller
  // either sends again in the same step or calls settle_block, which lowers
  // valid, so valid is never dropped and raised within one step.
  // -------------------------------------------------------------------------
  task automatic send_word(input bit present, input logic [WORD_W-1:0] word,
                           input bit last);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_present <= present;
    in_sample_word    <= word;
    in_batch_last     <= last;
    // Stall is read at the falling edge before the accepting edge, when it is settled.
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    absorb_word(present, word, last);
    words_sent++;
  endtask

  // Waits until every queued result has come back, then lets the block run
  // out its latency. With at_end set, anything still queued is a failure.
  task automatic settle_block(input bit at_end);
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_gestures.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (at_end && expected_gestures.size() != 0) begin
      $error("%0d expected result words never arrived", expected_gestures.size());
      mismatch_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, with the enable lowered behind it so that the enable
  // is never lowered and raised in the same step.
  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[COORD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_REGS) thresh[idx] = value & COORD_MAX;
    @(posedge clk);
  endtask

  task automatic apply_thresholds(input int band_lo, input int band_hi, input int lbx,
                                  input int lby, input int rbx, input int rby);
    write_reg(CFG_SLIDER_X_LOW, band_lo);
    write_reg(CFG_SLIDER_X_HIGH, band_hi);
    write_reg(CFG_LEFT_BUTTON_X, lbx);
    write_reg(CFG_LEFT_BUTTON_Y, lby);
    write_reg(CFG_RIGHT_BUTTON_X, rbx);
    write_reg(CFG_RIGHT_BUTTON_Y, rby);
    settings_used++;
  endtask

  // -------------------------------------------------------------------------
  // Random batch. Most batches aim at a spot that matters under the current
  // thresholds (slider band, a button, an edge of a region), so that presses,
  // holds, misses and releases all happen; the rest are raw noise.
  // -------------------------------------------------------------------------
  task automatic send_random_batch();
    int kind, len, tx, ty, dir, step, jit, d, i;
    bit absent_close, noisy, present;
    logic [WORD_W-1:0] word;
    kind = $urandom_range(0, 9);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    jit  = $urandom_range(0, 8);
    dir  = int'($urandom_range(0, 2)) - 1;
    step = $urandom_range(0, 40);
    noisy = 1'b0;
    d = int'($urandom_range(0, 4)) - 2;
    case (kind)
      0, 1, 2: begin
        tx = pick_between(thresh[CFG_SLIDER_X_LOW] + 1, thresh[CFG_SLIDER_X_HIGH] - 1);
        ty = $urandom_range(0, COORD_MAX);
        if (dir == 0 && $urandom_range(0, 1)) dir = 1;
      end
      3, 4: begin
        tx = pick_between(0, thresh[CFG_LEFT_BUTTON_X] - 1);
        ty = pick_between(thresh[CFG_LEFT_BUTTON_Y] + 1, COORD_MAX);
        dir = 0;
      end
      5, 6: begin
        tx = pick_between(thresh[CFG_RIGHT_BUTTON_X] + 1, COORD_MAX);
        ty = pick_between(thresh[CFG_RIGHT_BUTTON_Y] + 1, COORD_MAX);
        dir = 0;
      end
      7: begin
        // A still finger exactly around one edge, so the average is exact.
        jit = 0;
        dir = 0;
        case ($urandom_range(0, 5))
          0: begin
            tx = thresh[CFG_LEFT_BUTTON_X] - MARGIN + d;
            ty = thresh[CFG_LEFT_BUTTON_Y] + 1;
          end
          1: begin
            tx = thresh[CFG_RIGHT_BUTTON_X] + MARGIN + d;
            ty = thresh[CFG_RIGHT_BUTTON_Y] + 1;
          end
          2: begin
            tx = thresh[CFG_SLIDER_X_LOW] + d;
            ty = $urandom_range(0, COORD_MAX);
          end
          3: begin
            tx = thresh[CFG_SLIDER_X_HIGH] + d;
            ty = $urandom_range(0, COORD_MAX);
          end
          4: begin
            tx = thresh[CFG_LEFT_BUTTON_X] - 1 + d;
            ty = thresh[CFG_LEFT_BUTTON_Y] + d;
          end
          default: begin
            tx = thresh[CFG_RIGHT_BUTTON_X] + d;
            ty = thresh[CFG_RIGHT_BUTTON_Y] + d;
          end
        endcase
      end
      default: begin
        noisy = 1'b1;
        tx = 0;
        ty = 0;
      end
    endcase
    absent_close = ($urandom_range(0, 5) == 0);
    for (i = 0; i < len; i++) begin
      if (noisy) begin
        word    = WORD_W'($urandom());
        present = bit'($urandom_range(0, 1));
      end else begin
        word = pack_xy(tx + int'($urandom_range(0, 2 * jit)) - jit,
                       ty + dir * step * (i - len / 2) +
                       int'($urandom_range(0, 2 * jit)) - jit);
        present = ($urandom_range(0, 11) != 0);
      end
      send_word(present, word, (i == len - 1) && !absent_close);
    end
    // The batch may also be closed by a word that carries no sample.
    if (absent_close) send_word(1'b0, WORD_W'($urandom()), 1'b1);
  endtask

  task automatic run_phase(input int item_goal);
    int start;
    start     = words_sent;
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    while (words_sent - start < item_goal) begin
      // Flip the idle switches now and then for stretches of full speed.
      if ($urandom_range(0, 7) == 0) in_quiet = ~in_quiet;
      if ($urandom_range(0, 7) == 0) out_quiet = ~out_quiet;
      send_random_batch();
    end
    settle_block(1'b0);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Short directed walk through the reset thresholds: every gesture, the
  // hold hit, a release after three misses, and the odd batch shapes.
  task automatic test_directed_gestures();
    int i;
    // An empty batch classifies as none and stays quiet.
    send_word(1'b0, 24'h000000, 1'b1);
    // A single sample cannot be averaged; all word bits high.
    send_word(1'b1, 24'hFFFFFF, 1'b1);
    // Rising Y inside the slider band.
    send_word(1'b1, pack_xy(2000, 100), 1'b0);
    send_word(1'b1, pack_xy(2000, 200), 1'b0);
    send_word(1'b1, pack_xy(2000, 300), 1'b1);
    // Falling Y, closed by a word without a sample.
    send_word(1'b1, pack_xy(2000, 900), 1'b0);
    send_word(1'b1, pack_xy(2000, 800), 1'b0);
    send_word(1'b1, pack_xy(2000, 700), 1'b0);
    send_word(1'b1, pack_xy(2000, 600), 1'b0);
    send_word(1'b0, 24'h5A5A5A, 1'b1);
    // Left button press, then one batch that holds it.
    send_word(1'b1, pack_xy(500, 3500), 1'b0);
    send_word(1'b1, pack_xy(500, 3500), 1'b1);
    send_word(1'b1, pack_xy(500, 3500), 1'b1);
    // Three misses in a row release the button.
    send_word(1'b0, 24'hA5A5A5, 1'b1);
    send_word(1'b1, 24'h000000, 1'b1);
    send_word(1'b0, 24'h000000, 1'b1);
    // Right press at the corner; the all-zero last sample is left out.
    send_word(1'b1, 24'hFFFFFF, 1'b0);
    send_word(1'b1, 24'h000000, 1'b1);
    // Hold batch longer than the hold window: only the first samples count.
    for (i = 0; i < HOLD_CAP + 2; i++)
      send_word(1'b1, (i < HOLD_CAP) ? pack_xy(4000, 4000) : 24'h000000,
                i == HOLD_CAP + 1);
    settle_block(1'b0);
  endtask

  // All thresholds at zero and at full scale, plus writes to the unused
  // indexes, which must leave the thresholds alone.
  task automatic test_register_extremes();
    apply_thresholds(0, 0, 0, 0, 0, 0);
    write_reg(CFG_SPARE_LO, COORD_MAX);
    run_phase(110);
    apply_thresholds(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    write_reg(CFG_SPARE_HI, $urandom_range(0, COORD_MAX));
    run_phase(110);
  endtask

  // Random, narrow and wide settings, then back to the reset values.
  task automatic test_random_settings();
    int lo;
    apply_thresholds($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    run_phase(125);
    // A band one code wide and large buttons that are easy to hit.
    lo = $urandom_range(0, COORD_MAX - 2);
    apply_thresholds(lo, lo + 2, pick_between(1500, COORD_MAX), pick_between(0, 1500),
                     pick_between(0, 2500), pick_between(0, 1500));
    run_phase(125);
    apply_thresholds(pick_between(0, 400), pick_between(3600, COORD_MAX),
                     1000, 3000, 3000, 3000);
    run_phase(125);
    apply_thresholds(1600, 2496, 1000, 3000, 3000, 3000);
    run_phase(125);
  endtask

  // -------------------------------------------------------------------------
  // Result checker. Stall is planned one word ahead: after each accepted
  // word a hold-off is drawn, and stall stays high while it counts down
  // in cycles with a word waiting. Everything is read at the falling edge,
  // so a word seen there with stall low is taken at the next rising edge.
  // -------------------------------------------------------------------------
  task automatic check_result();
    gesture_word_t want;
    if (expected_gestures.size() == 0) begin
      $error("result word with nothing expected: gesture %0d notify %0d mouse_state %0d",
             out_gesture, out_notify, out_mouse_state);
      mismatch_count++;
      return;
    end
    want = expected_gestures.pop_front();
    results_seen++;
    if (want.gesture == G_SLIDER_UP || want.gesture == G_SLIDER_DOWN) slider_seen++;
    else if (want.gesture != G_NONE) press_seen++;
    else if (want.notify) release_seen++;
    if (out_gesture !== want.gesture) begin
      $error("gesture: expected %0d, actual %0d", want.gesture, out_gesture);
      mismatch_count++;
    end
    if (out_notify !== want.notify) begin
      $error("notify: expected %0d, actual %0d", want.notify, out_notify);
      mismatch_count++;
    end
    if (out_mouse_state !== want.mouse_state) begin
      $error("mouse_state: expected %0d, actual %0d", want.mouse_state, out_mouse_state);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1) begin
        if (stall_left > 0) begin
          stall_left--;
          @(posedge clk);
          if (stall_left == 0) out_stall <= 1'b0;
        end else begin
          check_result();
          @(posedge clk);
          stall_left = draw_wait(out_quiet);
          if (stall_left > 0) out_stall <= 1'b1;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Sequence: reset once, directed walk, register extremes, random settings,
  // final drain and verdict.
  // -------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_addr          <= '0;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_sample_present <= 1'b0;
    in_sample_word    <= '0;
    in_batch_last     <= 1'b0;
    out_stall         <= 1'b0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_gestures();
    test_register_extremes();
    test_random_settings();
    settle_block(1'b1);

    $display("Covered %0d sample words in %0d batches under %0d threshold settings.",
             words_sent, batches_closed, settings_used);
    $display("Checked %0d results: %0d slider, %0d presses, %0d releases.",
             results_seen, slider_seen, press_seen, release_seen);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tgc_pkg.sv
sv/tgc_ctrl.sv
sv/tgc_datapath.sv
sv/touch_gesture_classifier_top.sv
sv/tgc_checker.sv
verif/tb_top.sv
